@@ rtl/wcsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wcsp_pkg;

    // chunk and file tags, little-endian as they arrive on the stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] MIN_FILE_LEN = 32'd44;
    localparam int unsigned FMT_BYTES    = 16;
    localparam int unsigned HDR_BYTES    = 8;
    localparam int unsigned IDX_W        = $clog2(FMT_BYTES + 1);

    localparam int unsigned TDATA_W = 176;

    // final status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
    localparam logic [2:0] ST_BAD_RIFF    = 3'd2;
    localparam logic [2:0] ST_BAD_WAVE    = 3'd3;
    localparam logic [2:0] ST_SHORT_FMT   = 3'd4;
    localparam logic [2:0] ST_DATA_PAST   = 3'd5;
    localparam logic [2:0] ST_MISSING     = 3'd6;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_first;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/wcsp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcsp_core
    import wcsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic [7:0]  byte_value,
    input  wire logic        cfg_fire,
    input  wire logic [31:0] cfg_data,
    output logic             res_valid,
    output result_t          res
);

    typedef enum logic [2:0] {
        PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_BODY, PH_PAD, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER, KIND_FMT, KIND_DATA
    } kind_t;

    phase_t             phase_reg, phase_next;
    kind_t              chunk_kind_reg, chunk_kind_next;
    logic [31:0]        file_length_reg, file_length_next;
    logic [31:0]        byte_offset_reg, byte_offset_next;
    logic [31:0]        chunk_remaining_reg, chunk_remaining_next;
    logic [63:0]        header_shift_reg, header_shift_next;
    logic               pad_pending_reg, pad_pending_next;
    logic               fmt_seen_reg, fmt_seen_next;
    logic               data_seen_reg, data_seen_next;
    logic [127:0]       fmt_words_reg, fmt_words_next;
    logic [31:0]        data_size_reg, data_size_next;
    logic [IDX_W-1:0]   body_idx_reg, body_idx_next;

    logic [63:0]        shifted;
    logic [32:0]        pos_plus1;
    logic [31:0]        remaining_dec;
    logic [31:0]        hdr_id;
    logic [31:0]        hdr_size;
    logic [32:0]        data_end;
    logic [32:0]        fmt_end;

    assign shifted       = {byte_value, header_shift_reg[63:8]};
    assign pos_plus1     = {1'b0, byte_offset_reg} + 33'd1;
    assign remaining_dec = chunk_remaining_reg - 32'd1;
    assign hdr_id        = shifted[31:0];
    assign hdr_size      = shifted[63:32];
    assign data_end      = pos_plus1 + {1'b0, hdr_size};
    assign fmt_end       = pos_plus1 + 33'(FMT_BYTES);

    always_comb
    begin
        logic       emit;
        logic       pv;
        logic       pf;
        logic       done;
        logic [2:0] st;
        logic       ok;

        phase_next           = phase_reg;
        chunk_kind_next      = chunk_kind_reg;
        file_length_next     = file_length_reg;
        byte_offset_next     = byte_offset_reg;
        chunk_remaining_next = chunk_remaining_reg;
        header_shift_next    = header_shift_reg;
        pad_pending_next     = pad_pending_reg;
        fmt_seen_next        = fmt_seen_reg;
        data_seen_next       = data_seen_reg;
        fmt_words_next       = fmt_words_reg;
        data_size_next       = data_size_reg;
        body_idx_next        = body_idx_reg;
        emit = 1'b0;
        pv   = 1'b0;
        pf   = 1'b0;
        done = 1'b0;
        st   = ST_OK;

        if (byte_valid && phase_reg != PH_DONE)
        begin
            if (byte_offset_reg == 32'd0 && file_length_reg < MIN_FILE_LEN)
            begin
                done = 1'b1;
                st   = ST_TOO_SMALL;
            end
            else
            begin
                unique case (phase_reg)
                    PH_RIFF:
                    begin
                        header_shift_next = shifted;
                        if (byte_offset_reg >= 32'd3)
                        begin
                            if (shifted[63:32] != TAG_RIFF)
                            begin
                                done = 1'b1;
                                st   = ST_BAD_RIFF;
                            end
                            else
                            begin
                                phase_next = PH_SIZE;
                            end
                        end
                    end
                    PH_SIZE:
                    begin
                        if (byte_offset_reg >= 32'd7)
                        begin
                            phase_next = PH_WAVE;
                        end
                    end
                    PH_WAVE:
                    begin
                        header_shift_next = shifted;
                        if (byte_offset_reg >= 32'd11)
                        begin
                            if (shifted[63:32] != TAG_WAVE)
                            begin
                                done = 1'b1;
                                st   = ST_BAD_WAVE;
                            end
                            else
                            begin
                                phase_next           = PH_HDR;
                                chunk_remaining_next = 32'(HDR_BYTES);
                            end
                        end
                    end
                    PH_HDR:
                    begin
                        header_shift_next    = shifted;
                        chunk_remaining_next = remaining_dec;
                        if (remaining_dec == 32'd0)
                        begin
                            pad_pending_next     = hdr_size[0];
                            chunk_remaining_next = hdr_size;
                            chunk_kind_next      = KIND_OTHER;
                            body_idx_next        = '0;
                            if (hdr_id == TAG_FMT)
                            begin
                                if (hdr_size < 32'(FMT_BYTES)
                                    || fmt_end > {1'b0, file_length_reg})
                                begin
                                    done = 1'b1;
                                    st   = ST_SHORT_FMT;
                                end
                                else
                                begin
                                    chunk_kind_next = KIND_FMT;
                                    fmt_words_next  = '0;
                                end
                            end
                            else if (hdr_id == TAG_DATA)
                            begin
                                if (data_end > {1'b0, file_length_reg})
                                begin
                                    done = 1'b1;
                                    st   = ST_DATA_PAST;
                                end
                                else
                                begin
                                    chunk_kind_next = KIND_DATA;
                                    data_seen_next  = 1'b1;
                                    data_size_next  = hdr_size;
                                    if (hdr_size == 32'd0)
                                    begin
                                        // empty data chunk still marks a new chunk
                                        pf   = 1'b1;
                                        emit = 1'b1;
                                        if (fmt_seen_reg)
                                        begin
                                            done = 1'b1;
                                            st   = ST_OK;
                                        end
                                    end
                                end
                            end
                            if (!done)
                            begin
                                if (hdr_size == 32'd0)
                                begin
                                    phase_next           = PH_HDR;
                                    chunk_remaining_next = 32'(HDR_BYTES);
                                end
                                else
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (chunk_kind_reg == KIND_FMT)
                        begin
                            for (int i = 0; i < FMT_BYTES; i++)
                            begin
                                if (body_idx_reg == IDX_W'(i))
                                begin
                                    fmt_words_next[i*8 +: 8] = byte_value;
                                end
                            end
                        end
                        if (body_idx_reg < IDX_W'(FMT_BYTES))
                        begin
                            body_idx_next = body_idx_reg + IDX_W'(1);
                        end
                        if (chunk_kind_reg == KIND_DATA)
                        begin
                            pv   = 1'b1;
                            pf   = (body_idx_reg == '0);
                            emit = 1'b1;
                        end
                        chunk_remaining_next = remaining_dec;
                        if (chunk_kind_reg == KIND_FMT
                            && body_idx_reg == IDX_W'(FMT_BYTES - 1))
                        begin
                            fmt_seen_next = 1'b1;
                            if (data_seen_reg)
                            begin
                                done = 1'b1;
                                st   = ST_OK;
                            end
                        end
                        if (!done && remaining_dec == 32'd0)
                        begin
                            if (chunk_kind_reg == KIND_DATA && fmt_seen_reg)
                            begin
                                done = 1'b1;
                                st   = ST_OK;
                            end
                            else if (pad_pending_reg)
                            begin
                                phase_next = PH_PAD;
                            end
                            else
                            begin
                                phase_next           = PH_HDR;
                                chunk_remaining_next = 32'(HDR_BYTES);
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        phase_next           = PH_HDR;
                        chunk_remaining_next = 32'(HDR_BYTES);
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            // last byte of the file without a verdict
            if (!done && pos_plus1 == {1'b0, file_length_reg})
            begin
                done = 1'b1;
                st   = ST_MISSING;
            end
            byte_offset_next = pos_plus1[31:0];
            if (done)
            begin
                phase_next = PH_DONE;
            end
        end

        // a length write starts a new file
        if (cfg_fire)
        begin
            file_length_next     = cfg_data;
            phase_next           = PH_RIFF;
            chunk_kind_next      = KIND_OTHER;
            byte_offset_next     = '0;
            chunk_remaining_next = '0;
            header_shift_next    = '0;
            pad_pending_next     = 1'b0;
            fmt_seen_next        = 1'b0;
            data_seen_next       = 1'b0;
            fmt_words_next       = '0;
            data_size_next       = '0;
            body_idx_next        = '0;
        end

        ok        = done && st == ST_OK;
        res_valid = emit || done;
        res.payload_valid     = pv;
        res.payload_byte      = pv ? byte_value : 8'd0;
        res.payload_first     = pf;
        res.done_res          = done;
        res.status            = st;
        res.format_tag        = ok ? fmt_words_next[15:0]    : 16'd0;
        res.channel_count     = ok ? fmt_words_next[31:16]   : 16'd0;
        res.sample_rate       = ok ? fmt_words_next[63:32]   : 32'd0;
        res.avg_bytes_per_sec = ok ? fmt_words_next[95:64]   : 32'd0;
        res.block_align       = ok ? fmt_words_next[111:96]  : 16'd0;
        res.bits_per_sample   = ok ? fmt_words_next[127:112] : 16'd0;
        res.data_length       = ok ? data_size_next          : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_RIFF;
            chunk_kind_reg      <= KIND_OTHER;
            file_length_reg     <= '0;
            byte_offset_reg     <= '0;
            chunk_remaining_reg <= '0;
            header_shift_reg    <= '0;
            pad_pending_reg     <= 1'b0;
            fmt_seen_reg        <= 1'b0;
            data_seen_reg       <= 1'b0;
            fmt_words_reg       <= '0;
            data_size_reg       <= '0;
            body_idx_reg        <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            chunk_kind_reg      <= chunk_kind_next;
            file_length_reg     <= file_length_next;
            byte_offset_reg     <= byte_offset_next;
            chunk_remaining_reg <= chunk_remaining_next;
            header_shift_reg    <= header_shift_next;
            pad_pending_reg     <= pad_pending_next;
            fmt_seen_reg        <= fmt_seen_next;
            data_seen_reg       <= data_seen_next;
            fmt_words_reg       <= fmt_words_next;
            data_size_reg       <= data_size_next;
            body_idx_reg        <= body_idx_next;
        end
    end

    // header countdown never leaves its range
    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR |-> (chunk_remaining_reg != 32'd0
                                 && chunk_remaining_reg <= 32'(HDR_BYTES)))
        else $error("header byte count out of range");

    // audio bytes only come out of a data chunk body
    a_payload_src: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && res_valid && res.payload_valid)
            |-> (phase_reg == PH_BODY && chunk_kind_reg == KIND_DATA))
        else $error("payload byte outside data chunk body");

    // a verdict parks the parser
    a_done_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && res.done_res && !cfg_fire) |=> phase_reg == PH_DONE)
        else $error("parser did not stop after final status");

endmodule

`default_nettype wire

@@ rtl/wcsp_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wcsp_out_buf
    import wcsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    push;
    logic    main_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (push)
        begin
            skid_reg <= in_data;
        end
    end

    // skid only fills behind a held main stage
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds data with main stage empty");

    // a drained main stage is refilled from the skid stage
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid stage did not drain");

endmodule

`default_nettype wire

@@ rtl/wav_chunk_stream_parser.sv @@
// results are registered: the combinational parse step feeds the output stage, which drives m_tvalid
// throughput: one byte per cycle while s_tready is high, set by the single-pass parse step and two-entry output stage
// s_tready drops only while both output entries hold results the sink has not taken
// reset: all parser state cleared, file length 0, so the first byte reports too small
// a cfg write of the file length restarts the parser; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module wav_chunk_stream_parser
    import wcsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // file byte stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] byte_value

    // parse results
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] payload_byte, [10:8] status, [26:11] format_tag,
    // [42:27] channel_count, [74:43] sample_rate, [106:75] avg_bytes_per_sec,
    // [122:107] block_align, [138:123] bits_per_sample, [170:139] data_length,
    // [175:171] zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [1:0]              m_tuser,   // [0] payload_valid, [1] payload_first
    output logic                    m_tlast,   // done_res

    // file length register
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);

    logic    in_fire;
    logic    cfg_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // the register is taken in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_tvalid && s_tready;

    // parse step: state update and result for the byte in this transfer
    wcsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_fire),
        .byte_value (s_tdata),
        .cfg_fire   (cfg_fire),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register plus skid entry, so bytes keep flowing while the sink stalls until the skid entry fills
    wcsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {5'd0,
                      out_res.data_length,
                      out_res.bits_per_sample,
                      out_res.block_align,
                      out_res.avg_bytes_per_sec,
                      out_res.sample_rate,
                      out_res.channel_count,
                      out_res.format_tag,
                      out_res.status,
                      out_res.payload_byte};
    assign m_tuser = {out_res.payload_first, out_res.payload_valid};
    assign m_tlast = out_res.done_res;

endmodule

`default_nettype wire
